>>> design/ghash_pkg.sv
// Shared types and constants of the GHASH accumulator.
package ghash_pkg;

   // Widths of the hash block, the bit counters and the per-word bit increment.
   localparam int BLOCK_W = 128;
   localparam int HALF_W  = 64;
   localparam int COUNT_W = 64;
   localparam int BITS_W  = 8;
   localparam int VB_W    = 5;
   localparam int BYTES   = 16;

   // Command codes of an input word.
   localparam logic [1:0] CMD_AAD    = 2'd0;
   localparam logic [1:0] CMD_TEXT   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;
   localparam logic [1:0] CMD_NONE   = 2'd3;

   // Register indexes of the configuration port.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_HI = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_KEY_LO = 1'b1;

   // A registered, already padded input word.
   typedef struct packed {
      logic               fin;
      logic               is_aad;
      logic [BLOCK_W-1:0] block;
      logic [BITS_W-1:0]  bits;
   } item_type;

   // A finished hash handed to the result buffer.
   typedef struct packed {
      logic               valid;
      logic [BLOCK_W-1:0] hash;
   } result_type;

endpackage

>>> design/ghash_accumulator.sv
// Top level of the GHASH accumulator.
// Takes one word per clock cycle, unless stalled, with no start-up pass after reset.
// A word is held in the input register, where it is folded into the accumulator by a fully
// unrolled GF(2^128) multiply; a finish word's hash goes on into the result buffer, whose
// output register drives rsp_. The input side stalls only when two finished hashes wait to
// be taken and a third finish is next in line. The user must write the hash key via csr_
// (index 0: upper half, 1: lower half) only while no word is in flight; not enforced here.
module ghash_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [ghash_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ghash_pkg::HALF_W-1:0]        csr_wdata,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [ghash_pkg::HALF_W-1:0]        req_data_hi,
   input  logic [ghash_pkg::HALF_W-1:0]        req_data_lo,
   input  logic [ghash_pkg::VB_W-1:0]          req_valid_bytes,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ghash_pkg::HALF_W-1:0]        rsp_hash_hi,
   output logic [ghash_pkg::HALF_W-1:0]        rsp_hash_lo
);
   import ghash_pkg::*;

   logic       item_valid;
   item_type   item;
   logic       advance;
   logic       room;
   result_type result;

   // Padding and input register.
   ghash_input u_input (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_data_hi     (req_data_hi),
      .req_data_lo     (req_data_lo),
      .req_valid_bytes (req_valid_bytes),
      .advance         (advance),
      .item_valid      (item_valid),
      .item            (item)
   );

   // Accumulator, counters and key.
   ghash_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item_valid   (item_valid),
      .item         (item),
      .room         (room),
      .advance      (advance),
      .result       (result)
   );

   // Result register with skid.
   ghash_out_buf u_out_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (result),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_hash_hi (rsp_hash_hi),
      .rsp_hash_lo (rsp_hash_lo)
   );

endmodule

>>> design/ghash_input.sv
// Input stage: zero-pads a data word and holds it in the input register.
module ghash_input (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_cmd,
   input  logic [ghash_pkg::HALF_W-1:0] req_data_hi,
   input  logic [ghash_pkg::HALF_W-1:0] req_data_lo,
   input  logic [ghash_pkg::VB_W-1:0] req_valid_bytes,
   input  logic                       advance,
   output logic                       item_valid,
   output ghash_pkg::item_type        item
);
   import ghash_pkg::*;

   logic               item_valid_ff, item_valid_in;
   item_type           item_ff, item_in;
   logic [VB_W-1:0]    vb_eff;
   logic [BLOCK_W-1:0] mask;
   logic               useful;
   logic               accept;

   // Oversized counts act as a full word.
   assign vb_eff = (req_valid_bytes > VB_W'(BYTES)) ? VB_W'(BYTES) : req_valid_bytes;

   // Keep the leading valid bytes, byte 0 at the top.
   always_comb begin
      mask = '0;
      for (int k = 0; k < BYTES; k++) begin
         if (VB_W'(k) < vb_eff) begin
            mask[BLOCK_W-1-8*k -: 8] = 8'hFF;
         end
      end
   end

   // Unused commands and empty absorb words leave no trace.
   assign useful = (req_cmd == CMD_FINISH) ||
                   ((req_cmd != CMD_NONE) && (req_valid_bytes != '0));

   assign req_stall = item_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in.fin    = (req_cmd == CMD_FINISH);
      item_in.is_aad = (req_cmd == CMD_AAD);
      item_in.block  = {req_data_hi, req_data_lo} & mask;
      item_in.bits   = {vb_eff, 3'b000};
   end

   // The input register empties on advance and refills on a useful word.
   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = useful;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

   // A stall is only raised while a word waits in the input register.
   assert property (@(posedge clock) disable iff (reset) req_stall |-> item_valid_ff)
      else $error("input stall without a held word");

endmodule

>>> design/ghash_gfmul.sv
// GF(2^128) multiplier in the bit-reflected GCM convention.
module ghash_gfmul (
   input  logic [ghash_pkg::BLOCK_W-1:0] op_x,
   input  logic [ghash_pkg::BLOCK_W-1:0] op_h,
   output logic [ghash_pkg::BLOCK_W-1:0] product
);
   import ghash_pkg::*;

   localparam int PROD_W = 2 * BLOCK_W - 1;
   localparam int HI_W   = PROD_W - BLOCK_W;
   localparam int FOLD_W = HI_W + 7;
   localparam int TAIL_W = FOLD_W - BLOCK_W;
   localparam int LAST_W = TAIL_W + 7;

   // The top bit of a word is the x^0 coefficient.
   function automatic logic [BLOCK_W-1:0] reflect(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      for (int i = 0; i < BLOCK_W; i++) begin
         r[i] = v[BLOCK_W-1-i];
      end
      return r;
   endfunction

   logic [BLOCK_W-1:0] a, b, c;
   logic [PROD_W-1:0]  p;
   logic [HI_W-1:0]    hi;
   logic [FOLD_W-1:0]  t;
   logic [TAIL_W-1:0]  f;
   logic [LAST_W-1:0]  g;

   assign a = reflect(op_x);
   assign b = reflect(op_h);

   // Carry-less product as an XOR of shifted partial products.
   always_comb begin
      p = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (a[i]) begin
            p = p ^ ({{(PROD_W-BLOCK_W){1'b0}}, b} << i);
         end
      end
   end

   // Reduce by x^128 + x^7 + x^2 + x + 1 in two folds.
   assign hi = p[PROD_W-1:BLOCK_W];
   assign t  = {7'b0, hi} ^ {6'b0, hi, 1'b0} ^ {5'b0, hi, 2'b0} ^ {hi, 7'b0};
   assign f  = t[FOLD_W-1:BLOCK_W];
   assign g  = {7'b0, f} ^ {6'b0, f, 1'b0} ^ {5'b0, f, 2'b0} ^ {f, 7'b0};
   assign c  = p[BLOCK_W-1:0] ^ t[BLOCK_W-1:0] ^ {{(BLOCK_W-LAST_W){1'b0}}, g};

   assign product = reflect(c);

endmodule

>>> design/ghash_core.sv
// Hash key, accumulator and bit counters; one multiply per word.
module ghash_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [ghash_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ghash_pkg::HALF_W-1:0]       csr_wdata,
   input  logic                               item_valid,
   input  ghash_pkg::item_type                item,
   input  logic                               room,
   output logic                               advance,
   output ghash_pkg::result_type              result
);
   import ghash_pkg::*;

   logic [HALF_W-1:0]  key_hi_ff, key_lo_ff;
   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] aad_len_ff, aad_len_in;
   logic [COUNT_W-1:0] text_bits_ff, text_bits_in;
   logic [BLOCK_W-1:0] operand, product;
   logic               fin_fire;

   // A finish needs a free slot in the result buffer.
   assign advance  = item_valid && (!item.fin || room);
   assign fin_fire = advance && item.fin;

   // A finish absorbs the length block instead of data.
   assign operand = acc_ff ^ (item.fin ? {aad_len_ff, text_bits_ff} : item.block);

   ghash_gfmul u_gfmul (
      .op_x    (operand),
      .op_h    ({key_hi_ff, key_lo_ff}),
      .product (product)
   );

   // Next accumulator and counters.
   always_comb begin
      acc_in       = acc_ff;
      aad_len_in   = aad_len_ff;
      text_bits_in = text_bits_ff;
      if (advance) begin
         if (item.fin) begin
            acc_in       = '0;
            aad_len_in   = '0;
            text_bits_in = '0;
         end else begin
            acc_in = product;
            if (item.is_aad) begin
               aad_len_in = aad_len_ff + {{(COUNT_W-BITS_W){1'b0}}, item.bits};
            end else begin
               text_bits_in = text_bits_ff + {{(COUNT_W-BITS_W){1'b0}}, item.bits};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         acc_ff       <= '0;
         aad_len_ff   <= '0;
         text_bits_ff <= '0;
      end else begin
         acc_ff       <= acc_in;
         aad_len_ff   <= aad_len_in;
         text_bits_ff <= text_bits_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_KEY_HI: key_hi_ff <= csr_wdata;
               REG_KEY_LO: key_lo_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   assign result.valid = fin_fire;
   assign result.hash  = product;

   // A finish leaves the hash state cleared.
   assert property (@(posedge clock) disable iff (reset)
      fin_fire |=> (acc_ff == '0) && (aad_len_ff == '0) && (text_bits_ff == '0))
      else $error("hash state not cleared after finish");

   // An AAD word never moves the ciphertext count.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !item.fin && item.is_aad) |=> (text_bits_ff == $past(text_bits_ff)))
      else $error("ciphertext count changed by an AAD word");

endmodule

>>> design/ghash_out_buf.sv
// Two-entry result buffer: output register plus skid register.
module ghash_out_buf (
   input  logic                         clock,
   input  logic                         reset,
   input  ghash_pkg::result_type        push,
   output logic                         room,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [ghash_pkg::HALF_W-1:0] rsp_hash_hi,
   output logic [ghash_pkg::HALF_W-1:0] rsp_hash_lo
);
   import ghash_pkg::*;

   logic               out_valid_ff, out_valid_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [BLOCK_W-1:0] out_ff, out_in;
   logic [BLOCK_W-1:0] skid_ff, skid_in;
   logic               take;

   assign take = out_valid_ff && !rsp_stall;
   assign room = !(out_valid_ff && skid_valid_ff);

   // Head refills from the skid register first, keeping order.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            if (push.valid) begin
               skid_in = push.hash;
            end else begin
               skid_valid_in = 1'b0;
            end
         end else if (push.valid) begin
            out_in = push.hash;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (push.valid) begin
         if (!out_valid_ff) begin
            out_in       = push.hash;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push.hash;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_hash_hi = out_ff[BLOCK_W-1:HALF_W];
   assign rsp_hash_lo = out_ff[HALF_W-1:0];

   // The skid register only fills behind a held head.
   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> out_valid_ff)
      else $error("skid word without a head word");

   // A push never lands on a full buffer.
   assert property (@(posedge clock) disable iff (reset)
      (push.valid && !take) |-> !(out_valid_ff && skid_valid_ff))
      else $error("result buffer overflow");

endmodule

>>> test/ghash_accumulator_tb.sv
// Self-checking testbench of the GHASH accumulator: directed words, then random messages.
module ghash_accumulator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ghash_pkg::*;

   localparam int SETTLE_CYCLES   = 6;
   localparam int WORDS_PER_PHASE = 265;
   localparam int N_PHASES        = 5;
   localparam int N_DIRECTED      = 23;

   localparam logic [63:0] ONES = '1;
   localparam logic [63:0] PAT_A = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PAT_B = 64'hFEDC_BA98_7654_3210;
   localparam logic [63:0] PAT_C = 64'hA5C3_0F96_5A3C_F069;
   localparam logic [63:0] PAT_D = 64'h8001_7FFE_C33C_1248;

   // One directed word; hash_known marks a finish whose hash is typed in by hand.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] data_hi;
      logic [63:0] data_lo;
      logic [4:0]  valid_bytes;
      logic        hash_known;
      logic [63:0] hash_hi;
      logic [63:0] hash_lo;
   } directed_row_type;

   // The directed part runs with H equal to one, so each hash is the XOR of the padded
   // blocks and the length block.
   localparam directed_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{CMD_FINISH, ONES,  ONES,  5'd31, 1'b1, 64'h0, 64'h0},
      '{CMD_AAD,    ONES,  ONES,  5'd16, 1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, 64'h0, 64'h0, 5'd0,  1'b1, 64'hFFFF_FFFF_FFFF_FF7F, ONES},
      '{CMD_TEXT,   ONES,  ONES,  5'd1,  1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, 64'h0, 64'h0, 5'd16, 1'b1, 64'hFF00_0000_0000_0000, 64'h8},
      '{CMD_AAD,    ONES,  ONES,  5'd8,  1'b0, 64'h0, 64'h0},
      '{CMD_AAD,    ONES,  ONES,  5'd9,  1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, ONES,  64'h0, 5'd1,  1'b1, 64'h88, 64'hFF00_0000_0000_0000},
      '{CMD_NONE,   ONES,  ONES,  5'd16, 1'b0, 64'h0, 64'h0},
      '{CMD_AAD,    ONES,  ONES,  5'd0,  1'b0, 64'h0, 64'h0},
      '{CMD_TEXT,   ONES,  ONES,  5'd0,  1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, 64'h0, ONES,  5'd8,  1'b1, 64'h0, 64'h0},
      '{CMD_TEXT,   ONES,  ONES,  5'd31, 1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, 64'h0, 64'h0, 5'd16, 1'b1, ONES, 64'hFFFF_FFFF_FFFF_FF7F},
      '{CMD_AAD,    64'h0, 64'h0, 5'd16, 1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, ONES,  ONES,  5'd16, 1'b1, 64'h80, 64'h0},
      '{CMD_AAD,    PAT_A, PAT_B, 5'd15, 1'b0, 64'h0, 64'h0},
      '{CMD_TEXT,   PAT_B, PAT_A, 5'd16, 1'b0, 64'h0, 64'h0},
      '{CMD_AAD,    PAT_C, PAT_D, 5'd2,  1'b0, 64'h0, 64'h0},
      '{CMD_TEXT,   PAT_D, PAT_C, 5'd12, 1'b0, 64'h0, 64'h0},
      '{CMD_TEXT,   PAT_A, PAT_D, 5'd17, 1'b0, 64'h0, 64'h0},
      '{CMD_AAD,    PAT_B, PAT_C, 5'd7,  1'b0, 64'h0, 64'h0},
      '{CMD_FINISH, PAT_C, PAT_A, 5'd3,  1'b0, 64'h0, 64'h0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = REG_KEY_HI;
   logic [HALF_W-1:0]        csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_cmd = CMD_AAD;
   logic [HALF_W-1:0]        req_data_hi = '0;
   logic [HALF_W-1:0]        req_data_lo = '0;
   logic [VB_W-1:0]          req_valid_bytes = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [HALF_W-1:0]        rsp_hash_hi;
   logic [HALF_W-1:0]        rsp_hash_lo;

   // Hand-typed hash that travels with the word on the request side.
   logic                     word_hash_known = 1'b0;
   logic [BLOCK_W-1:0]       word_hash = '0;

   // Predictor state: key, running accumulator and bit counts.
   logic [BLOCK_W-1:0]       key_h = '0;
   logic [BLOCK_W-1:0]       acc_x = '0;
   logic [COUNT_W-1:0]       aad_len = '0;
   logic [COUNT_W-1:0]       text_bits = '0;

   logic [BLOCK_W-1:0]       hash_expected_q [$];
   int                       fail_count = 0;
   bit                       idle_on = 1'b1;
   bit                       calm = 1'b0;

   ghash_accumulator DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_data_hi     (req_data_hi),
      .req_data_lo     (req_data_lo),
      .req_valid_bytes (req_valid_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hash_hi     (rsp_hash_hi),
      .rsp_hash_lo     (rsp_hash_lo)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // GF(2^128) product in the reflected bit order, reduced by 0xE1.
   function automatic logic [127:0] gf128_mult(input logic [127:0] x, input logic [127:0] h);
      logic [127:0] z;
      logic [127:0] v;
      z = '0;
      v = h;
      for (int i = 127; i >= 0; i--) begin
         if (x[i]) z ^= v;
         v = v[0] ? ((v >> 1) ^ {8'hE1, 120'b0}) : (v >> 1);
      end
      return z;
   endfunction

   // Keep the leading n bytes of a block and clear the rest.
   function automatic logic [127:0] pad_block(input logic [127:0] blk, input int n);
      logic [127:0] mask;
      mask = '1;
      mask = mask << (8 * (16 - n));
      return blk & mask;
   endfunction

   // Fold one accepted word into the predictor; returns 1 when it finishes a hash.
   function automatic bit fold_word(input logic [1:0] cmd, input logic [63:0] hi,
                                    input logic [63:0] lo, input logic [4:0] vb,
                                    output logic [127:0] hash);
      int n;
      hash = '0;
      if (cmd == CMD_FINISH) begin
         acc_x = gf128_mult(acc_x ^ {aad_len, text_bits}, key_h);
         hash = acc_x;
         acc_x = '0;
         aad_len = '0;
         text_bits = '0;
         return 1'b1;
      end
      if (cmd == CMD_NONE || vb == 5'd0) return 1'b0;
      n = (vb > 5'd16) ? 16 : int'(vb);
      acc_x = gf128_mult(acc_x ^ pad_block({hi, lo}, n), key_h);
      if (cmd == CMD_AAD) aad_len += 64'(8 * n);
      else text_bits += 64'(8 * n);
      return 1'b0;
   endfunction

   // Check each taken hash against the oldest expectation, then predict from the taken word.
   always @(posedge clock) begin : word_monitor
      logic [127:0] hash;
      logic [127:0] want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (hash_expected_q.size() == 0) begin
               $error("hash word with none expected: %h %h", rsp_hash_hi, rsp_hash_lo);
               fail_count++;
            end else begin
               want = hash_expected_q.pop_front();
               if (rsp_hash_hi !== want[127:64]) begin
                  $error("hash_hi: expected %h, got %h", want[127:64], rsp_hash_hi);
                  fail_count++;
               end
               if (rsp_hash_lo !== want[63:0]) begin
                  $error("hash_lo: expected %h, got %h", want[63:0], rsp_hash_lo);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (fold_word(req_cmd, req_data_hi, req_data_lo, req_valid_bytes, hash))
               hash_expected_q.push_back(word_hash_known ? word_hash : hash);
         end
      end
   end

   // Result side backpressure: random bursts of stall while idling is allowed.
   always begin
      @(posedge clock);
      if (idle_on && !reset && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   function automatic logic [63:0] rand_half();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Present one word, with an optional gap first, and return at the edge that takes it.
   task automatic send_word(input logic [1:0] cmd, input logic [63:0] hi, input logic [63:0] lo,
                            input logic [4:0] vb, input bit known = 1'b0,
                            input logic [127:0] hash = '0);
      int gap;
      gap = (idle_on && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_data_hi     <= hi;
      req_data_lo     <= lo;
      req_valid_bytes <= vb;
      word_hash_known <= known;
      word_hash       <= hash;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold the sender back until every expected hash has been taken.
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (hash_expected_q.size() != 0);
   endtask

   // Drain, then let the last absorb words leave the pipeline.
   task automatic settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
      csr_write_en <= 1'b1;
      csr_index    <= REG_KEY_HI;
      csr_wdata    <= hi;
      @(posedge clock);
      csr_index    <= REG_KEY_LO;
      csr_wdata    <= lo;
      @(posedge clock);
      csr_write_en <= 1'b0;
      key_h = {hi, lo};
   endtask

   // A word the block ignores: the unused command or an empty block.
   task automatic send_noise();
      if ($urandom_range(0, 1))
         send_word(CMD_NONE, rand_half(), rand_half(), 5'($urandom_range(0, 31)));
      else
         send_word($urandom_range(0, 1) ? CMD_TEXT : CMD_AAD, rand_half(), rand_half(), 5'd0);
   endtask

   // Random messages: AAD blocks, then ciphertext blocks, then a finish. A few interleave
   // the two kinds, and ignored words are sprinkled in between.
   task automatic run_messages(input int target);
      int         words;
      int         msgs;
      int         n_aad;
      int         n_blocks;
      int         r;
      bit         mixed;
      bit         last;
      logic [1:0] cmd;
      logic [4:0] vb;
      words = 0;
      msgs = 0;
      while (words < target) begin
         idle_on  = !calm && ($urandom_range(0, 3) != 0);
         n_aad    = $urandom_range(0, 4);
         n_blocks = n_aad + $urandom_range(0, 10);
         mixed    = ($urandom_range(0, 7) == 0);
         for (int k = 0; k < n_blocks; k++) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            if (mixed) cmd = $urandom_range(0, 1) ? CMD_TEXT : CMD_AAD;
            else cmd = (k < n_aad) ? CMD_AAD : CMD_TEXT;
            last = (k == n_aad - 1) || (k == n_blocks - 1);
            r = $urandom_range(0, 11);
            if (r == 0) vb = 5'($urandom_range(17, 31));
            else if (last || r == 1) vb = 5'($urandom_range(1, 16));
            else vb = 5'd16;
            send_word(cmd, rand_half(), rand_half(), vb);
            words++;
         end
         send_word(CMD_FINISH, rand_half(), rand_half(), 5'($urandom_range(0, 31)));
         words++;
         msgs++;
         if (msgs % 20 == 3) hold_until_drained();
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed words with H equal to one.
      write_key(64'h8000_0000_0000_0000, 64'h0);
      for (int r = 0; r < N_DIRECTED; r++)
         send_word(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].data_hi, DIRECTED_ROWS[r].data_lo,
                   DIRECTED_ROWS[r].valid_bytes, DIRECTED_ROWS[r].hash_known,
                   {DIRECTED_ROWS[r].hash_hi, DIRECTED_ROWS[r].hash_lo});
      settle();

      // Random phases, each under its own key; the last one runs without idling.
      for (int p = 0; p < N_PHASES; p++) begin
         case (p)
            0: write_key(ONES, ONES);
            1: write_key(64'h0, 64'h0);
            default: write_key({$urandom, $urandom}, {$urandom, $urandom});
         endcase
         calm = (p == N_PHASES - 1);
         run_messages(WORDS_PER_PHASE);
         settle();
      end

      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> files.f
design/ghash_pkg.sv
design/ghash_input.sv
design/ghash_gfmul.sv
design/ghash_core.sv
design/ghash_out_buf.sv
design/ghash_accumulator.sv
test/ghash_accumulator_tb.sv
